// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module of the project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while the synchronous reset is held low.
`define FPCM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define FPCM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/fpcm_pkg.sv =====
// Package for the floating-point compare, min/max, class and sign block.
// Holds command codes, format constants, the decoded operand type and helpers.
package fpcm_pkg;

  localparam int CMD_W       = 4;
  localparam int XLEN        = 64;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 64;
  localparam int CLASS_W     = 10;

  localparam logic [CMD_W-1:0] CMD_FMIN   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_FMAX   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_FEQ    = 4'd2;
  localparam logic [CMD_W-1:0] CMD_FLT    = 4'd3;
  localparam logic [CMD_W-1:0] CMD_FLE    = 4'd4;
  localparam logic [CMD_W-1:0] CMD_FCLASS = 4'd5;
  localparam logic [CMD_W-1:0] CMD_FSGNJ  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_FSGNJN = 4'd7;
  localparam logic [CMD_W-1:0] CMD_FSGNJX = 4'd8;

  localparam logic [XLEN-1:0] BOX_MASK = 64'hffff_ffff_0000_0000;
  localparam logic [XLEN-1:0] QNAN_D   = 64'h7ff8_0000_0000_0000;
  localparam logic [31:0]     QNAN_S   = 32'h7fc0_0000;
  localparam logic [XLEN-1:0] SIGN_D   = 64'h8000_0000_0000_0000;
  localparam logic [XLEN-1:0] SIGN_S   = 64'h0000_0000_8000_0000;

  typedef struct packed {
    logic [XLEN-1:0] bits;  // value within its format width
    logic [XLEN-1:0] mag;   // value with the sign bit cleared
    logic            neg;
    logic            nan;
    logic            snan;
    logic            zero;
    logic            inf;
    logic            sub;
  } fpcm_val_t;

  typedef struct packed {
    logic [XLEN-1:0] result;
    logic            invalid;
  } fpcm_res_t;

  // Strict less-than on two values that are not NaN.
  function automatic logic fp_less(fpcm_val_t a, fpcm_val_t b);
    logic lt;
    if (a.zero && b.zero) begin
      lt = 1'b0;
    end else if (a.neg != b.neg) begin
      lt = a.neg;
    end else if (a.neg) begin
      lt = (a.mag > b.mag);
    end else begin
      lt = (a.mag < b.mag);
    end
    return lt;
  endfunction

  // Singles are returned NaN-boxed.
  function automatic logic [XLEN-1:0] fp_box(logic [XLEN-1:0] x, logic dbl);
    return dbl ? x : (BOX_MASK | {32'h0, x[31:0]});
  endfunction

endpackage

// ===== rtl/core/fp_compare_minmax_class_sign_top.sv =====
// Floating-point fmin/fmax/feq/flt/fle/fclass/fsgnj block for RISC-V F and D.
// A word accepted into the input register passes to the result register and is
// shown on the output from there, leaving when out_tready is high.
// Throughput: one word per cycle unless out_tready stalls; the input register feeds
// one pass of decode and operation logic into the result register.
// Reset (rst_n low, synchronous) empties both registers; payload is not reset.
module fp_compare_minmax_class_sign_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // command[3:0], operand_a[67:4], operand_b[131:68]
  input  logic [fpcm_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tuser,   // is_double[0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fpcm_pkg::OUT_TDATA_W-1:0]  out_tdata,  // result[63:0]
  output logic                              out_tuser   // invalid_flag[0]
);
  import fpcm_pkg::*;

  logic              s1_valid_r;
  logic [CMD_W-1:0]  s1_cmd_r;
  logic              s1_dbl_r;
  logic [XLEN-1:0]   s1_a_r;
  logic [XLEN-1:0]   s1_b_r;
  logic              out_valid_r;
  logic [XLEN-1:0]   out_data_r;
  logic              out_inv_r;
  logic              s1_move;
  logic              in_take;
  fpcm_val_t         dec_a;
  fpcm_val_t         dec_b;
  fpcm_res_t         exe_res;

  // The result register is free when empty or being taken this cycle.
  assign s1_move   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_move;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_move) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r <= in_tdata[3:0];
      s1_a_r   <= in_tdata[67:4];
      s1_b_r   <= in_tdata[131:68];
      s1_dbl_r <= in_tuser;
    end
    if (s1_move && s1_valid_r) begin
      out_data_r <= exe_res.result;
      out_inv_r  <= exe_res.invalid;
    end
  end

  fpcm_decode u_dec_a (
    .raw       (s1_a_r),
    .is_double (s1_dbl_r),
    .val       (dec_a)
  );

  fpcm_decode u_dec_b (
    .raw       (s1_b_r),
    .is_double (s1_dbl_r),
    .val       (dec_b)
  );

  fpcm_exec u_exec (
    .command   (s1_cmd_r),
    .is_double (s1_dbl_r),
    .a         (dec_a),
    .b         (dec_b),
    .res       (exe_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_inv_r;

endmodule

// ===== rtl/core/fpcm_decode.sv =====
// Operand decoder: unboxes a single or takes a double and derives its kind.
// Depends on fpcm_pkg.
module fpcm_decode (
  input  logic [63:0]          raw,
  input  logic                 is_double,
  output fpcm_pkg::fpcm_val_t  val
);
  import fpcm_pkg::*;

  logic [XLEN-1:0] x;
  logic            exp_ones;
  logic            exp_zero;
  logic            frac_nz;
  logic            quiet;

  always_comb begin
    if (is_double) begin
      x = raw;
    end else if ((raw & BOX_MASK) == BOX_MASK) begin
      x = {32'h0, raw[31:0]};
    end else begin
      // An improperly boxed single reads as the canonical quiet NaN.
      x = {32'h0, QNAN_S};
    end
  end

  assign exp_ones = is_double ? (&x[62:52]) : (&x[30:23]);
  assign exp_zero = is_double ? ~(|x[62:52]) : ~(|x[30:23]);
  assign frac_nz  = is_double ? (|x[51:0]) : (|x[22:0]);
  assign quiet    = is_double ? x[51] : x[22];

  always_comb begin
    val.bits = x;
    val.mag  = is_double ? {1'b0, x[62:0]} : {33'h0, x[30:0]};
    val.neg  = is_double ? x[63] : x[31];
    val.nan  = exp_ones && frac_nz;
    val.snan = exp_ones && frac_nz && !quiet;
    val.inf  = exp_ones && !frac_nz;
    val.zero = exp_zero && !frac_nz;
    val.sub  = exp_zero && frac_nz;
  end

endmodule

// ===== rtl/core/fpcm_exec.sv =====
// Operation logic for min/max, compares, class and sign injection.
// Depends on fpcm_pkg; takes two decoded operands from fpcm_decode.
module fpcm_exec (
  input  logic [3:0]           command,
  input  logic                 is_double,
  input  fpcm_pkg::fpcm_val_t  a,
  input  fpcm_pkg::fpcm_val_t  b,
  output fpcm_pkg::fpcm_res_t  res
);
  import fpcm_pkg::*;

  logic            lt_ab;
  logic            lt_ba;
  logic            any_nan;
  logic            any_snan;
  logic [XLEN-1:0] sign;
  logic [XLEN-1:0] mm;
  logic [XLEN-1:0] sgn_bit;
  logic [CLASS_W-1:0] cls;

  assign lt_ab    = fp_less(a, b);
  assign lt_ba    = fp_less(b, a);
  assign any_nan  = a.nan || b.nan;
  assign any_snan = a.snan || b.snan;
  assign sign     = is_double ? SIGN_D : SIGN_S;

  always_comb begin
    if (a.nan && b.nan) begin
      mm = is_double ? QNAN_D : {32'h0, QNAN_S};
    end else if (a.nan) begin
      mm = b.bits;
    end else if (b.nan) begin
      mm = a.bits;
    end else if (a.zero && b.zero) begin
      // Mixed-sign zeros: min takes -0, max takes +0.
      if (command == CMD_FMAX) begin
        mm = (a.neg && b.neg) ? sign : '0;
      end else begin
        mm = (a.neg || b.neg) ? sign : '0;
      end
    end else if (command == CMD_FMAX) begin
      mm = lt_ab ? b.bits : a.bits;
    end else begin
      mm = lt_ba ? b.bits : a.bits;
    end
  end

  always_comb begin
    cls = '0;
    if (a.nan) begin
      cls[a.snan ? 8 : 9] = 1'b1;
    end else if (a.inf) begin
      cls[a.neg ? 0 : 7] = 1'b1;
    end else if (a.zero) begin
      cls[a.neg ? 3 : 4] = 1'b1;
    end else if (a.sub) begin
      cls[a.neg ? 2 : 5] = 1'b1;
    end else begin
      cls[a.neg ? 1 : 6] = 1'b1;
    end
  end

  always_comb begin
    case (command)
      CMD_FSGNJ:  sgn_bit = b.neg ? sign : '0;
      CMD_FSGNJN: sgn_bit = b.neg ? '0 : sign;
      default:    sgn_bit = (a.neg != b.neg) ? sign : '0;
    endcase
  end

  always_comb begin
    res.result  = '0;
    res.invalid = 1'b0;
    case (command)
      CMD_FMIN, CMD_FMAX: begin
        res.result  = fp_box(mm, is_double);
        res.invalid = any_snan;
      end
      CMD_FEQ: begin
        res.invalid = any_snan;
        res.result  = {63'h0, !any_nan && ((a.zero && b.zero) || (a.bits == b.bits))};
      end
      CMD_FLT: begin
        res.invalid = any_nan;
        res.result  = {63'h0, !any_nan && lt_ab};
      end
      CMD_FLE: begin
        res.invalid = any_nan;
        res.result  = {63'h0, !any_nan && !lt_ba};
      end
      CMD_FCLASS: begin
        res.result = {{(XLEN-CLASS_W){1'b0}}, cls};
      end
      CMD_FSGNJ, CMD_FSGNJN, CMD_FSGNJX: begin
        res.result = fp_box(a.mag | sgn_bit, is_double);
      end
      default: begin
        res.result  = '0;
        res.invalid = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/fpcm_checker.sv =====
// Port-level checker for fp_compare_minmax_class_sign_top, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module fpcm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_tvalid,
  input logic          in_tready,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [63:0]   out_tdata,
  input logic          out_tuser
);

  // A reset cycle leaves the output empty.
  `FPCM_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_tvalid, "output valid after reset")

  // With the output empty, the pipeline can always take a word.
  `FPCM_ASSERT(a_ready_when_empty, clk, rst_n, !out_tvalid |-> in_tready, "not ready with empty output")

  // A word accepted, followed by a free output, passes the input and result registers and shows on out_tvalid.
  `FPCM_ASSERT(a_two_cycle_latency, clk, rst_n, (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid, "accepted word lost")

  // A stalled result holds its value and flag.
  `FPCM_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind fp_compare_minmax_class_sign_top fpcm_checker u_fpcm_checker (.*);
